>>> rtl/hsv_pkg.sv
// shared constants and beat types for the hsv to rgb pixel converter
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

  // fixed point format: FRAC_BITS fraction bits, ONE means 1.0
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned COMP_W    = FRAC_BITS + 1;
  localparam int unsigned HUE6_W    = FRAC_BITS + 3;
  localparam int unsigned SECTOR_W  = 3;
  localparam int unsigned NUM_SECTORS = 6;

  typedef logic [COMP_W-1:0] comp_t;

  localparam comp_t ONE = comp_t'(1) << FRAC_BITS;

  // color wheel sectors, one per sixth of the hue circle
  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // input beat
  typedef struct packed {
    comp_t hue;
    comp_t saturation;
    comp_t brightness;
  } pixel_hsv_t;

  // output beat
  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
  } pixel_rgb_t;

  // clamp a component to the range 0..ONE
  function automatic comp_t sat_one(input comp_t x);
    sat_one = (x > ONE) ? ONE : x;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hsv_fx_mul.sv
// registered fixed-point multiply with truncation of the fraction bits
`timescale 1ns / 1ps
`default_nettype none

module hsv_fx_mul (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire hsv_pkg::comp_t a_i,
  input  wire hsv_pkg::comp_t b_i,
  output hsv_pkg::comp_t     prod_o
);
  import hsv_pkg::*;

  logic [2*COMP_W-1:0] full_prod;
  comp_t               prod_d;
  comp_t               prod_q;

  // full product, then drop the low fraction bits (operands never exceed ONE)
  assign full_prod = (2*COMP_W)'(a_i) * (2*COMP_W)'(b_i);
  assign prod_d    = full_prod[FRAC_BITS +: COMP_W];

  // product register, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> rtl/hsv_to_rgb_pixel.sv
// hsv to rgb pixel converter, four register stages, one pixel per clock
//
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one hsv pixel per beat
//                 (hue, saturation, brightness, 4096 means 1.0, larger
//                 values clamp to 1.0)
//   out channel : out_valid_o / out_ready_i carry one rgb pixel per beat
//   path        : an input beat passes the stage 1, 2 and 3 registers and
//                 the output register before out_valid_o rises
//   throughput  : one pixel per clock unless the output stalls; the hue sextant
//                 split, the three 13x13 multiplies of stage 2 and the two of
//                 stage 3 each take one stage, every stage holds its own pixel
//   reset       : clears all stage valid bits, the pipeline comes up empty
//                 and ready; no clearing pass
//   stall       : while the output beat waits, the whole pipeline holds
//                 and in_ready_o drops; nothing is lost or repeated, and a
//                 new beat is taken in the same cycle the output is taken
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_pixel (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hsv_pkg::pixel_hsv_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hsv_pkg::pixel_rgb_t     out_data_o
);
  import hsv_pkg::*;

  // pipeline advance: the output register is free or is being emptied
  logic pipe_en;
  assign pipe_en    = !out_valid_o || out_ready_i;
  assign in_ready_o = pipe_en;

  // stage 1: clamp, hue times six, sector and fraction
  comp_t             hue_sat, sat_sat, val_sat;
  logic [HUE6_W-1:0] hue6;
  logic [SECTOR_W-1:0] sec_raw;
  sector_e           sector_d;

  logic    s1_valid_q;
  comp_t   s1_sat_q, s1_val_q, s1_frac_q;
  sector_e s1_sector_q;

  assign hue_sat = sat_one(in_data_i.hue);
  assign sat_sat = sat_one(in_data_i.saturation);
  assign val_sat = sat_one(in_data_i.brightness);
  assign hue6    = (HUE6_W'(hue_sat) << 2) + (HUE6_W'(hue_sat) << 1);
  assign sec_raw = hue6[FRAC_BITS +: SECTOR_W];

  // sextant index; hue of one lands past the last sector and wraps
  always_comb begin
    case (sec_raw)
      SEC_RED_YEL: sector_d = SEC_RED_YEL;
      SEC_YEL_GRN: sector_d = SEC_YEL_GRN;
      SEC_GRN_CYN: sector_d = SEC_GRN_CYN;
      SEC_CYN_BLU: sector_d = SEC_CYN_BLU;
      SEC_BLU_MAG: sector_d = SEC_BLU_MAG;
      SEC_MAG_RED: sector_d = SEC_MAG_RED;
      default:     sector_d = SEC_RED_YEL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_sat_q    <= sat_sat;
      s1_val_q    <= val_sat;
      s1_frac_q   <= {1'b0, hue6[FRAC_BITS-1:0]};
      s1_sector_q <= sector_d;
    end
  end

  // stage 2: s*f, s*(1-f) and p = v*(1-s)
  comp_t sf_q, snf_q, p_q;
  logic    s2_valid_q;
  comp_t   s2_val_q;
  sector_e s2_sector_q;

  hsv_fx_mul u_mul_sf (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .a_i    (s1_sat_q),
    .b_i    (s1_frac_q),
    .prod_o (sf_q)
  );

  hsv_fx_mul u_mul_snf (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .a_i    (s1_sat_q),
    .b_i    (ONE - s1_frac_q),
    .prod_o (snf_q)
  );

  hsv_fx_mul u_mul_p (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .a_i    (s1_val_q),
    .b_i    (ONE - s1_sat_q),
    .prod_o (p_q)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_val_q    <= s1_val_q;
      s2_sector_q <= s1_sector_q;
    end
  end

  // stage 3: q = v*(1-s*f), t = v*(1-s*(1-f))
  comp_t q_q, t_q;
  logic    s3_valid_q;
  comp_t   s3_val_q, s3_p_q;
  sector_e s3_sector_q;

  hsv_fx_mul u_mul_q (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .a_i    (s2_val_q),
    .b_i    (ONE - sf_q),
    .prod_o (q_q)
  );

  hsv_fx_mul u_mul_t (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .a_i    (s2_val_q),
    .b_i    (ONE - snf_q),
    .prod_o (t_q)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_val_q    <= s2_val_q;
      s3_p_q      <= p_q;
      s3_sector_q <= s2_sector_q;
    end
  end

  // stage 4: route v, p, q, t to the channels by sector
  pixel_rgb_t rgb_d;
  pixel_rgb_t out_data_q;
  logic       out_valid_q;

  always_comb begin
    case (s3_sector_q)
      SEC_RED_YEL: rgb_d = '{red: s3_val_q, green: t_q,      blue: s3_p_q};
      SEC_YEL_GRN: rgb_d = '{red: q_q,      green: s3_val_q, blue: s3_p_q};
      SEC_GRN_CYN: rgb_d = '{red: s3_p_q,   green: s3_val_q, blue: t_q};
      SEC_CYN_BLU: rgb_d = '{red: s3_p_q,   green: q_q,      blue: s3_val_q};
      SEC_BLU_MAG: rgb_d = '{red: t_q,      green: s3_p_q,   blue: s3_val_q};
      default:     rgb_d = '{red: s3_val_q, green: s3_p_q,   blue: q_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_data_q <= rgb_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // no component ever exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.red <= ONE && out_data_o.green <= ONE &&
                     out_data_o.blue <= ONE))
    else $error("rgb component above one");

  // p, q and t never exceed the brightness of the same pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_p_q <= s3_val_q && q_q <= s3_val_q && t_q <= s3_val_q))
    else $error("derived component above brightness");

  // a held pipeline keeps its occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable({s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q}))
    else $error("stage valid bits moved during stall");

  // an output beat leaves only when the receiver takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output beat dropped or changed while stalled");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the hsv to rgb pixel converter
`timescale 1ns / 1ps

module testbench;
  import hsv_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_PRINTS    = 20;
  localparam int unsigned FIELD_MAX     = (1 << COMP_W) - 1;

  // one row of the directed table, with an optional hand-typed answer
  typedef struct {
    pixel_hsv_t px;
    bit         typed;
    pixel_rgb_t rgb;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  pixel_hsv_t in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  pixel_rgb_t out_data_o;

  // answer that travels with the current beat when the table gives one
  bit         typed_ok;
  pixel_rgb_t typed_rgb;

  pixel_rgb_t  expected_rgb[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatches;
  int unsigned pixels_in;
  int unsigned pixels_out;
  int unsigned grey_pixels;
  int unsigned clamped_pixels;
  int unsigned in_stall_cycles;
  int unsigned longest_hold;
  int unsigned cycle_count;
  bit          smooth_flow;

  hsv_to_rgb_pixel i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // clamp a component to 1.0
  function automatic logic [31:0] clamp_unit(input comp_t x);
    return (x > ONE) ? 32'(ONE) : 32'(x);
  endfunction

  // fixed point hsv to rgb conversion, products truncated
  function automatic pixel_rgb_t convert_hsv(input pixel_hsv_t px);
    logic [31:0] h, s, v, h6, f, p, q, t, r, g, b, unit;
    sector_e     sec;
    pixel_rgb_t  rgb;
    unit = 32'(ONE);
    h    = clamp_unit(px.hue);
    s    = clamp_unit(px.saturation);
    v    = clamp_unit(px.brightness);
    h6   = h * NUM_SECTORS;
    f    = h6 & (unit - 1);
    sec  = sector_e'(3'(((h6 >> FRAC_BITS) % NUM_SECTORS)));
    p    = (v * (unit - s)) >> FRAC_BITS;
    q    = (v * (unit - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
    t    = (v * (unit - ((s * (unit - f)) >> FRAC_BITS))) >> FRAC_BITS;
    if (s == 0) begin
      r = v; g = v; b = v;
    end else begin
      case (sec)
        SEC_RED_YEL: begin r = v; g = t; b = p; end
        SEC_YEL_GRN: begin r = q; g = v; b = p; end
        SEC_GRN_CYN: begin r = p; g = v; b = t; end
        SEC_CYN_BLU: begin r = p; g = q; b = v; end
        SEC_BLU_MAG: begin r = t; g = p; b = v; end
        default:     begin r = v; g = p; b = q; end
      endcase
    end
    rgb.red   = comp_t'(r);
    rgb.green = comp_t'(g);
    rgb.blue  = comp_t'(b);
    return rgb;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at output pixel %0d: %s got %0d expected %0d",
               pixels_out, what, got, want);
  endtask

  function automatic void add_row(input int unsigned h, input int unsigned s,
                                  input int unsigned v, input bit typed,
                                  input int unsigned r, input int unsigned g,
                                  input int unsigned b);
    dir_row_t row;
    row.px.hue        = comp_t'(h);
    row.px.saturation = comp_t'(s);
    row.px.brightness = comp_t'(v);
    row.typed         = typed;
    row.rgb.red       = comp_t'(r);
    row.rgb.green     = comp_t'(g);
    row.rgb.blue      = comp_t'(b);
    directed_rows.push_back(row);
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (smooth_flow || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // component value biased toward the valid range and its edges
  function automatic comp_t random_component();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return comp_t'($urandom_range(0, ONE));
    if (roll < 80) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return comp_t'(1);
        2:       return ONE - comp_t'(1);
        default: return ONE;
      endcase
    end
    return comp_t'($urandom_range(0, FIELD_MAX));
  endfunction

  // offer one beat; entered and left at a falling edge
  task automatic send_pixel(input pixel_hsv_t px, input bit typed,
                            input pixel_rgb_t rgb);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    typed_ok   <= typed;
    typed_rgb  <= rgb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // beat monitor: check output beats, queue expectations for input beats
  always @(posedge clk_i) begin
    pixel_rgb_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch("beat with nothing expected, red", out_data_o.red, 0);
        end else begin
          want = expected_rgb.pop_front();
          if (out_data_o.red !== want.red)
            report_mismatch("red", out_data_o.red, want.red);
          if (out_data_o.green !== want.green)
            report_mismatch("green", out_data_o.green, want.green);
          if (out_data_o.blue !== want.blue)
            report_mismatch("blue", out_data_o.blue, want.blue);
        end
        pixels_out++;
      end
      if (in_valid_i && in_ready_o) begin
        expected_rgb.push_back(typed_ok ? typed_rgb : convert_hsv(in_data_i));
        pixels_in++;
        if (clamp_unit(in_data_i.saturation) == 0) grey_pixels++;
        if (in_data_i.hue > ONE || in_data_i.saturation > ONE ||
            in_data_i.brightness > ONE)
          clamped_pixels++;
      end
      if (in_valid_i && !in_ready_o) in_stall_cycles++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected",
               cycle_count, expected_rgb.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output side: random stalls plus one long hold to back up the pipeline
  initial begin
    int unsigned stall;
    int unsigned held;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && pixels_out >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        longest_hold = held;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // reset, directed table, random pixels, drain and verdict
  initial begin
    pixel_hsv_t px;
    pixel_rgb_t no_rgb;
    int unsigned n;
    no_rgb      = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    typed_ok    = 1'b0;
    typed_rgb   = '0;
    smooth_flow = 1'b0;

    // values with an obvious answer
    add_row(0,    0,    0,    1, 0,    0,    0);
    add_row(0,    0,    ONE,  1, ONE,  ONE,  ONE);
    add_row(1234, 0,    2048, 1, 2048, 2048, 2048);
    add_row(0,    0,    5000, 1, ONE,  ONE,  ONE);
    add_row(FIELD_MAX, FIELD_MAX, FIELD_MAX, 1, ONE, 0, 0);
    add_row(ONE,  ONE,  ONE,  1, ONE,  0,    0);
    add_row(0,    ONE,  ONE,  1, ONE,  0,    0);
    add_row(0,    FIELD_MAX, 0, 1, 0,  0,    0);
    // one pixel per sector, then the sector borders
    add_row(341,  3000, 3500, 0, 0, 0, 0);
    add_row(1024, 3000, 3500, 0, 0, 0, 0);
    add_row(1707, 3000, 3500, 0, 0, 0, 0);
    add_row(2048, 3000, 3500, 0, 0, 0, 0);
    add_row(2731, 3000, 3500, 0, 0, 0, 0);
    add_row(3700, 3000, 3500, 0, 0, 0, 0);
    add_row(682,  ONE,  ONE,  0, 0, 0, 0);
    add_row(683,  ONE,  ONE,  0, 0, 0, 0);
    add_row(1365, ONE,  ONE,  0, 0, 0, 0);
    add_row(1366, ONE,  ONE,  0, 0, 0, 0);
    add_row(ONE - 1, ONE, ONE, 0, 0, 0, 0);
    add_row(2048, ONE,  ONE,  0, 0, 0, 0);
    // smallest saturation, hue above one, saturation above one, fraction bits all set
    add_row(1500, 1,    ONE,  0, 0, 0, 0);
    add_row(5000, 2000, 3000, 0, 0, 0, 0);
    add_row(2500, 6000, 4000, 0, 0, 0, 0);
    add_row(ONE - 1, ONE - 1, ONE - 1, 0, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].rgb);

    for (n = 0; n < RANDOM_PIXELS; n++) begin
      // one stretch with no idling on either side
      smooth_flow = (n >= 400 && n < 500);
      px.hue        = random_component();
      px.saturation = ($urandom_range(0, 9) == 0) ? comp_t'(0) : random_component();
      px.brightness = random_component();
      send_pixel(px, 1'b0, no_rgb);
    end
    in_valid_i <= 1'b0;

    while (expected_rgb.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("converted %0d pixels (%0d from the table), %0d grey, %0d with clamped inputs",
             pixels_out, directed_rows.size(), grey_pixels, clamped_pixels);
    $display("output held off for %0d cycles at once, input stalled %0d cycles",
             longest_hold, in_stall_cycles);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hsv_pkg.sv
rtl/hsv_fx_mul.sv
rtl/hsv_to_rgb_pixel.sv
dv/testbench.sv
